// ===== sv/sfl_pkg.sv =====
package sfl_pkg;

    localparam int unsigned MAX_CELLS_DEF = 4096;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned ATTR_W     = 8;
    localparam int unsigned STAT_W     = 3;
    localparam int unsigned CELLS_W    = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;

    localparam int unsigned CELLS_RESET = 1920;
    localparam logic [ATTR_W-1:0] PMASK_RESET = 8'd32;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_CURSOR = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_OFFLINE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNFMT    = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOATTR   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FMT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PMASK  = 2'd3;

    localparam logic [1:0] PH_BACK = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_NEXT = 2'd2;

    typedef logic [1:0] t_phase;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic              use_cursor;
        logic [ATTR_W-1:0] attribute;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] field_start;
        logic [ATTR_W-1:0] field_attr;
        logic [ADDR_W-1:0] field_length;
        logic              length_valid;
        logic              is_protected;
        logic [ADDR_W-1:0] next_unprotected;
        logic              next_found;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    typedef struct packed {
        logic   clear;
        logic   accept;
        logic   scan;
        logic   check;
        t_phase phase;
        logic   load;
        t_phase load_phase;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic query_go;
        logic hit;
        logic exhausted;
    } t_sts;

endpackage

// ===== sv/sfl_chan_if.sv =====
interface sfl_chan_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/screen_field_locator_core.sv =====
// write, cursor, spare and rejected items: result valid the cycle after the transaction
// query: one cell read per cycle; a backward walk to the owning attribute (the query ends
//   there if none is found), a length walk and a forward walk, in that order;
//   one item in flight at a time
// reset: synchronous; the store is then cleared one cell per cycle, all MAX_CELLS cells,
//   with input ready low; the configuration port is always ready
module screen_field_locator_core import sfl_pkg::*; #(
    parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfl_chan_if.sink   i_req,
    sfl_chan_if.source o_rsp,
    sfl_chan_if.sink   i_cfg
);

    t_cmd cmd;
    t_sts sts;
    t_rsp rsp;

    assign i_cfg.ready   = 1'b1;
    assign o_rsp.payload = rsp;

    sfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sfl_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_req    (i_req.payload),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.payload),
        .o_rsp    (rsp)
    );

endmodule

// ===== sv/sfl_ctrl.sv =====
module sfl_ctrl import sfl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_BACK  = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_NEXT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.query_go) begin
                        o_cmd.load       = 1'b1;
                        o_cmd.load_phase = PH_BACK;
                        n_state          = S_BACK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_BACK: begin
                o_cmd.check = 1'b1;
                o_cmd.phase = PH_BACK;
                if (i_sts.hit) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.load_phase = PH_LEN;
                    n_state          = S_LEN;
                end else if (i_sts.exhausted) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_LEN: begin
                o_cmd.check = 1'b1;
                o_cmd.phase = PH_LEN;
                if (i_sts.hit || i_sts.exhausted) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.load_phase = PH_NEXT;
                    n_state          = S_NEXT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_NEXT: begin
                o_cmd.check = 1'b1;
                o_cmd.phase = PH_NEXT;
                if (i_sts.hit || i_sts.exhausted) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

`ifndef SYNTH
    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_in_ready)
        else $error("ready right after a transaction");

    a_next_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT && i_sts.hit) |=> o_out_valid)
        else $error("result not shown after the last walk");

    a_no_scan_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.scan))
        else $error("scan issued while loading a walk");
`endif

endmodule

// ===== sv/sfl_dp.sv =====
module sfl_dp import sfl_pkg::*; #(
    parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_req i_req,
    input  logic i_cfg_we,
    input  t_cfg i_cfg,
    output t_rsp o_rsp
);

    localparam int unsigned AW = $clog2(MAX_CELLS);
    localparam int unsigned NW = $clog2(MAX_CELLS + 2);
    localparam int unsigned EW = (NW > CELLS_W) ? NW : CELLS_W;
    localparam int unsigned XW = (NW > ADDR_W) ? NW : ADDR_W;
    localparam int unsigned RST_CELLS = (CELLS_RESET > MAX_CELLS) ? MAX_CELLS : CELLS_RESET;

    logic [NW-1:0]     r_cells;
    logic              r_online;
    logic              r_fmt;
    logic [ATTR_W-1:0] r_pmask;
    logic [ADDR_W-1:0] r_cursor;

    logic [ATTR_W-1:0] r_mem [MAX_CELLS];
    logic [AW-1:0]     r_clr_addr;

    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_raddr;
    logic [AW-1:0]     r_q;
    logic [NW-1:0]     r_left;
    logic              r_down;
    logic              r_rdv;
    logic [ATTR_W-1:0] r_rdata;
    logic [ATTR_W-1:0] r_prev;
    logic              r_first;
    logic [NW-1:0]     r_len;
    t_rsp              r_rsp;

    logic [EW-1:0]     cfg_ext;
    logic [NW-1:0]     cfg_cells;
    logic [ADDR_W-1:0] q_sel;
    logic              q_in_range;
    logic              addr_in_range;
    logic              issue;
    logic              hit;
    logic              exhausted;
    logic [AW-1:0]     load_addr;
    logic [NW-1:0]     load_left;
    logic              load_down;
    t_rsp              acc_rsp;

    function automatic logic [AW-1:0] f_step_up(input logic [AW-1:0] a,
                                                input logic [NW-1:0] n);
        logic [NW-1:0] inc;
        inc = NW'(a) + NW'(1);
        f_step_up = (inc >= n) ? '0 : AW'(inc);
    endfunction

    function automatic logic [AW-1:0] f_step_down(input logic [AW-1:0] a,
                                                  input logic [NW-1:0] n);
        f_step_down = (a == '0) ? AW'(n - NW'(1)) : a - AW'(1);
    endfunction

    // cell count clamp
    always_comb begin
        cfg_ext = EW'(i_cfg.data);
        if (cfg_ext == '0) begin
            cfg_cells = NW'(1);
        end else if (cfg_ext > EW'(MAX_CELLS)) begin
            cfg_cells = NW'(MAX_CELLS);
        end else begin
            cfg_cells = NW'(cfg_ext);
        end
    end

    assign q_sel         = i_req.use_cursor ? r_cursor : i_req.address;
    assign q_in_range    = XW'(q_sel) < XW'(r_cells);
    assign addr_in_range = XW'(i_req.address) < XW'(r_cells);

    assign issue     = i_cmd.scan && (r_left != '0);
    assign exhausted = (r_left == '0) && !r_rdv;

    always_comb begin
        hit = 1'b0;
        unique case (i_cmd.phase) inside
            PH_BACK, PH_LEN: hit = (r_rdata != '0);
            PH_NEXT: hit = !r_first && (r_prev != '0) && ((r_prev & r_pmask) == '0)
                           && (r_rdata == '0);
            default: hit = 1'b0;
        endcase
        hit = hit && r_rdv && i_cmd.check;
    end

    assign o_sts.clear_done = i_cmd.clear && (r_clr_addr == AW'(MAX_CELLS - 1));
    assign o_sts.query_go   = (i_req.op == OP_QUERY) && r_online && r_fmt && q_in_range;
    assign o_sts.hit        = hit;
    assign o_sts.exhausted  = exhausted;

    always_comb begin
        unique case (i_cmd.load_phase)
            PH_LEN: begin
                load_addr = f_step_up(r_raddr, r_cells);
                load_left = r_cells - NW'(1);
                load_down = 1'b0;
            end
            PH_NEXT: begin
                load_addr = r_q;
                load_left = r_cells + NW'(1);
                load_down = 1'b0;
            end
            default: begin
                load_addr = AW'(q_sel);
                load_left = r_cells;
                load_down = 1'b1;
            end
        endcase
    end

    always_comb begin
        acc_rsp = '0;
        unique case (i_req.op) inside
            OP_WRITE, OP_CURSOR: begin
                if (!addr_in_range) begin
                    acc_rsp.status = ST_RANGE;
                end
            end
            OP_QUERY: begin
                if (!r_online) begin
                    acc_rsp.status = ST_OFFLINE;
                end else if (!r_fmt) begin
                    acc_rsp.status = ST_UNFMT;
                end else if (!q_in_range) begin
                    acc_rsp.status = ST_RANGE;
                end else begin
                    acc_rsp.status = ST_OK;
                end
            end
            default: begin
                acc_rsp.status = ST_OK;
            end
        endcase
    end

    // configuration and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells  <= NW'(RST_CELLS);
            r_online <= 1'b0;
            r_fmt    <= 1'b0;
            r_pmask  <= PMASK_RESET;
            r_cursor <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg.index)
                    CFG_CELLS:  r_cells  <= cfg_cells;
                    CFG_ONLINE: r_online <= i_cfg.data[0];
                    CFG_FMT:    r_fmt    <= i_cfg.data[0];
                    CFG_PMASK:  r_pmask  <= i_cfg.data[ATTR_W-1:0];
                endcase
            end
            if (i_cmd.accept && (i_req.op == OP_CURSOR) && addr_in_range) begin
                r_cursor <= i_req.address;
            end
        end
    end

    // clearing pass pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // attribute store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.accept && (i_req.op == OP_WRITE) && addr_in_range) begin
            r_mem[AW'(i_req.address)] <= i_req.attribute;
        end
        if (issue) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdv <= 1'b0;
        end else if (i_cmd.load) begin
            r_rdv <= 1'b0;
        end else begin
            r_rdv <= issue;
        end
    end

    // walk address, count and pair tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_q <= AW'(q_sel);
        end
        if (issue) begin
            r_raddr <= r_addr;
            r_addr  <= r_down ? f_step_down(r_addr, r_cells) : f_step_up(r_addr, r_cells);
            r_left  <= r_left - NW'(1);
        end
        if (i_cmd.check && r_rdv && (i_cmd.phase == PH_NEXT)) begin
            r_prev  <= r_rdata;
            r_first <= 1'b0;
        end
        if (i_cmd.check && r_rdv && (i_cmd.phase == PH_LEN) && (r_rdata == '0)) begin
            r_len <= r_len + NW'(1);
        end
        if (i_cmd.load) begin
            r_addr  <= load_addr;
            r_left  <= load_left;
            r_down  <= load_down;
            r_first <= 1'b1;
            r_len   <= '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rsp <= acc_rsp;
        end else if (i_cmd.check) begin
            if (hit) begin
                unique case (i_cmd.phase)
                    PH_BACK: begin
                        r_rsp.field_start  <= ADDR_W'(r_raddr);
                        r_rsp.field_attr   <= r_rdata;
                        r_rsp.is_protected <= ((r_rdata & r_pmask) != '0);
                    end
                    PH_LEN: begin
                        r_rsp.field_length <= ADDR_W'(r_len);
                        r_rsp.length_valid <= 1'b1;
                    end
                    PH_NEXT: begin
                        r_rsp.next_unprotected <= ADDR_W'(r_raddr);
                        r_rsp.next_found       <= 1'b1;
                    end
                    default: begin
                        r_rsp.next_found <= r_rsp.next_found;
                    end
                endcase
            end else if (exhausted && (i_cmd.phase == PH_BACK)) begin
                r_rsp.status <= ST_NOATTR;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== tb/tb_screen_field_locator_core.sv =====
`timescale 1ns / 1ps

module tb_screen_field_locator_core import sfl_pkg::*;;

    localparam int unsigned MAX_CELLS   = MAX_CELLS_DEF;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned TAIL_CYCLES = 50;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    class field_scoreboard;
        logic [ATTR_W-1:0]  attr_cells [MAX_CELLS];
        logic [ADDR_W-1:0]  cursor;
        logic [CELLS_W-1:0] cells_reg;
        bit                 online;
        bit                 formatted;
        logic [ATTR_W-1:0]  pmask;
        t_rsp               expected_fields [$];
        int unsigned        errors;
        int unsigned        compared;
        int unsigned        requests;
        int unsigned        located;
        int unsigned        next_hits;

        function new();
            foreach (attr_cells[i]) attr_cells[i] = '0;
            cursor    = '0;
            cells_reg = CELLS_W'(CELLS_RESET);
            online    = 1'b0;
            formatted = 1'b0;
            pmask     = PMASK_RESET;
        endfunction

        function void set_reg(t_cfg c);
            case (c.index)
                CFG_CELLS:  cells_reg = c.data[CELLS_W-1:0];
                CFG_ONLINE: online    = c.data[0];
                CFG_FMT:    formatted = c.data[0];
                CFG_PMASK:  pmask     = c.data[ATTR_W-1:0];
            endcase
        endfunction

        function int unsigned cells_in_use();
            int unsigned n;
            n = cells_reg;
            if (n == 0) n = 1;
            if (n > MAX_CELLS) n = MAX_CELLS;
            return n;
        endfunction

        function int unsigned wrap_up(int unsigned a, int unsigned n);
            return (a + 1 >= n) ? 0 : a + 1;
        endfunction

        function t_rsp locate_field(t_req r);
            t_rsp        res;
            int unsigned n;
            int unsigned q;
            int unsigned a;
            int unsigned b;
            int unsigned nb;
            int unsigned len;
            bit          found;
            res = '0;
            n   = cells_in_use();
            if (r.op == OP_WRITE || r.op == OP_CURSOR) begin
                if (r.address >= n) begin
                    res.status = ST_RANGE;
                end else if (r.op == OP_WRITE) begin
                    attr_cells[r.address] = r.attribute;
                end else begin
                    cursor = r.address;
                end
                return res;
            end
            if (r.op != OP_QUERY) return res;
            if (!online) begin
                res.status = ST_OFFLINE;
                return res;
            end
            if (!formatted) begin
                res.status = ST_UNFMT;
                return res;
            end
            q = r.use_cursor ? cursor : r.address;
            if (q >= n) begin
                res.status = ST_RANGE;
                return res;
            end
            // backward walk to the owning attribute
            a = q;
            found = 1'b0;
            for (int unsigned i = 0; i < n; i++) begin
                if (attr_cells[a] != 0) begin
                    found = 1'b1;
                    break;
                end
                a = (a == 0) ? n - 1 : a - 1;
            end
            if (!found) begin
                res.status = ST_NOATTR;
                return res;
            end
            res.status       = ST_OK;
            res.field_start  = ADDR_W'(a);
            res.field_attr   = attr_cells[a];
            res.is_protected = (attr_cells[a] & pmask) != 0;
            // distance to the next attribute
            b = wrap_up(a, n);
            len = 0;
            while (b != a) begin
                if (attr_cells[b] != 0) begin
                    res.field_length = ADDR_W'(len);
                    res.length_valid = 1'b1;
                    break;
                end
                b = wrap_up(b, n);
                len++;
            end
            // first usable cell after an unprotected attribute
            nb = q;
            for (int unsigned i = 0; i < n; i++) begin
                b  = nb;
                nb = wrap_up(nb, n);
                if (attr_cells[b] != 0 && (attr_cells[b] & pmask) == 0
                        && attr_cells[nb] == 0) begin
                    res.next_unprotected = ADDR_W'(nb);
                    res.next_found       = 1'b1;
                    break;
                end
                if (nb == q) break;
            end
            return res;
        endfunction

        function void note_request(t_req r);
            t_rsp res;
            res = locate_field(r);
            requests++;
            if (r.op == OP_QUERY && res.status == ST_OK) located++;
            if (res.next_found) next_hits++;
            expected_fields.push_back(res);
        endfunction

        function int unsigned pending();
            return expected_fields.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            if (expected_fields.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            want = expected_fields.pop_front();
            compared++;
            compare_field("status", got.status, want.status);
            compare_field("field_start", got.field_start, want.field_start);
            compare_field("field_attr", got.field_attr, want.field_attr);
            compare_field("field_length", got.field_length, want.field_length);
            compare_field("length_valid", got.length_valid, want.length_valid);
            compare_field("is_protected", got.is_protected, want.is_protected);
            compare_field("next_unprotected", got.next_unprotected, want.next_unprotected);
            compare_field("next_found", got.next_found, want.next_found);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    sfl_chan_if #(.T_PAYLOAD(t_req)) req_ch ();
    sfl_chan_if #(.T_PAYLOAD(t_rsp)) rsp_ch ();
    sfl_chan_if #(.T_PAYLOAD(t_cfg)) cfg_ch ();

    screen_field_locator_core #(
        .MAX_CELLS(MAX_CELLS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    field_scoreboard sb = new();
    int unsigned     cycle_count = 0;
    int unsigned     hold_cycles = 0;
    int unsigned     stall_left  = 0;
    bit              quiet       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls plus long hold-offs on request
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.payload);
            if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.payload);
            if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
        end
    end

    task send_req(input t_req r);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task send_item(input logic [OP_W-1:0] op, input int unsigned addr, input bit uc,
                   input int unsigned attr);
        t_req r;
        r.op         = op;
        r.address    = ADDR_W'(addr);
        r.use_cursor = uc;
        r.attribute  = ATTR_W'(attr);
        send_req(r);
    endtask

    task random_items(input int unsigned count, input int unsigned n);
        t_req        r;
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) r.op = OP_WRITE;
            else if (pick < 50) r.op = OP_CURSOR;
            else if (pick < 93) r.op = OP_QUERY;
            else r.op = OP_SPARE;
            if ($urandom_range(0, 9) == 0) r.address = ADDR_W'($urandom_range(0, 4095));
            else r.address = ADDR_W'($urandom_range(0, n - 1));
            r.use_cursor = ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 2) == 0) r.attribute = '0;
            else r.attribute = ATTR_W'($urandom_range(1, 255));
            send_req(r);
        end
    endtask

    task wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        t_cfg c;
        c.index = idx;
        c.data  = CFG_DATA_W'(value);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= c;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task configure(input int unsigned cells, input bit online, input bit fmt,
                   input int unsigned mask);
        put_reg(CFG_CELLS, cells);
        put_reg(CFG_ONLINE, online);
        put_reg(CFG_FMT, fmt);
        put_reg(CFG_PMASK, mask);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int unsigned n_rand;
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.payload <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: offline, unformatted, 1920 cells
        send_item(OP_QUERY, 5, 1'b0, 0);
        send_item(OP_WRITE, 1919, 1'b0, 8'h20);
        send_item(OP_WRITE, 1920, 1'b0, 8'hFF);
        send_item(OP_CURSOR, 4095, 1'b1, 8'hFF);
        send_item(OP_SPARE, 4095, 1'b1, 8'hFF);
        wait_drained();
        configure(16, 1'b1, 1'b0, 32);
        send_item(OP_QUERY, 3, 1'b0, 0);
        wait_drained();
        configure(16, 1'b1, 1'b1, 32);
        send_item(OP_QUERY, 3, 1'b0, 0);
        send_item(OP_WRITE, 5, 1'b0, 8'h20);
        send_item(OP_QUERY, 9, 1'b0, 0);
        send_item(OP_QUERY, 2, 1'b0, 0);
        send_item(OP_WRITE, 10, 1'b0, 8'h01);
        send_item(OP_QUERY, 0, 1'b1, 0);
        send_item(OP_WRITE, 11, 1'b0, 8'h02);
        send_item(OP_CURSOR, 15, 1'b0, 0);
        send_item(OP_QUERY, 4095, 1'b1, 0);
        send_item(OP_WRITE, 15, 1'b0, 8'hFF);
        send_item(OP_QUERY, 15, 1'b0, 0);
        send_item(OP_QUERY, 16, 1'b0, 0);
        send_item(OP_QUERY, 4095, 1'b0, 0);
        send_item(OP_WRITE, 0, 1'b0, 8'hDF);
        send_item(OP_QUERY, 0, 1'b0, 0);
        wait_drained();
        // cursor left beyond a shrunken screen
        configure(8, 1'b1, 1'b1, 32);
        send_item(OP_QUERY, 0, 1'b1, 0);
        send_item(OP_CURSOR, 7, 1'b0, 0);
        send_item(OP_QUERY, 0, 1'b1, 0);
        wait_drained();
        // zero cells acts as a single cell
        configure(0, 1'b1, 1'b1, 8'h01);
        send_item(OP_WRITE, 0, 1'b0, 8'h40);
        send_item(OP_QUERY, 0, 1'b0, 0);
        send_item(OP_WRITE, 1, 1'b0, 8'h01);
        send_item(OP_QUERY, 0, 1'b1, 0);
        wait_drained();

        configure(16, 1'b1, 1'b1, 8'hFF);
        random_items(20, 16);
        wait_drained();
        configure(40, 1'b1, 1'b1, 8'h01);
        hold_cycles = 300;
        random_items(30, 40);
        wait_drained();
        configure(8191, 1'b1, 1'b1, $urandom_range(1, 255));
        random_items(8, MAX_CELLS);
        wait_drained();
        configure(64, 1'b0, 1'b1, 32);
        random_items(5, 64);
        wait_drained();
        configure(64, 1'b1, 1'b0, 32);
        random_items(5, 64);
        wait_drained();
        quiet = 1'b1;
        configure(64, 1'b1, 1'b1, 32);
        random_items(20, 64);
        wait_drained();
        quiet = 1'b0;
        n_rand = $urandom_range(2, 100);
        configure(n_rand, 1'b1, 1'b1, $urandom_range(1, 255));
        hold_cycles = 400;
        random_items(25, n_rand);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("summary: %0d requests, %0d results compared, %0d cycles",
                 sb.requests, sb.compared, cycle_count);
        $display("summary: %0d fields located, %0d with an unprotected field ahead",
                 sb.located, sb.next_hits);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
